/* sv/assert_macros.svh */
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, off while reset is high.
`define LPIB_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lpib assertion failed");

// Concurrent assertion that is also checked during reset.
`define LPIB_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("lpib reset assertion failed");

`endif

/* sv/lpib_pkg.sv */
// Package for the lidar point image box gate: widths, intrinsics, types.
// No dependencies.
`default_nettype none
package lpib_pkg;

  localparam int COORD_BITS     = 20;
  localparam int PIXEL_BITS     = 16;
  localparam int OFS_BITS       = 15;
  localparam int BOX_BITS       = 12;
  localparam int MARGIN_BITS    = 10;
  localparam int DEPTH_BITS     = 21;
  localparam int CFG_DATA_BITS  = 15;
  localparam int CFG_INDEX_BITS = 3;

  localparam int SUM_BITS   = COORD_BITS + 1;
  localparam int DIV_BITS   = SUM_BITS - 1;
  localparam int K_BITS     = 21;
  localparam int PROD_BITS  = SUM_BITS + K_BITS;
  localparam int SUMP_BITS  = PROD_BITS + 1;
  localparam int Q_FRAC     = 10;
  localparam int NSH_BITS   = SUMP_BITS - Q_FRAC;
  localparam int SHD_BITS   = SUM_BITS + PIXEL_BITS - 1;
  localparam int CMP_BITS   = ((NSH_BITS > SHD_BITS) ? NSH_BITS : SHD_BITS) + 1;
  localparam int SLOPE_BITS = 15;
  localparam int SEC_BITS   = COORD_BITS + SLOPE_BITS + 1;
  localparam int BND_BITS   = BOX_BITS + 2;
  localparam int QC_BITS    = ((PIXEL_BITS > BND_BITS) ? PIXEL_BITS : BND_BITS) + 1;

  // Q10 pinhole intrinsics
  localparam logic signed [K_BITS-1:0] FX_Q10 = K_BITS'(587796);
  localparam logic signed [K_BITS-1:0] CX_Q10 = K_BITS'(325835);
  localparam logic signed [K_BITS-1:0] FY_Q10 = K_BITS'(589051);
  localparam logic signed [K_BITS-1:0] CY_Q10 = K_BITS'(252483);

  // sector slope 1.5526 as 15526 / 10000
  localparam logic [SLOPE_BITS-1:0]        SLOPE_NUM = SLOPE_BITS'(15526);
  localparam logic signed [SLOPE_BITS-1:0] SLOPE_DEN = SLOPE_BITS'(10000);

  localparam logic signed [COORD_BITS-1:0] NOISE_S = COORD_BITS'(10);
  localparam logic [COORD_BITS-1:0]        NOISE_U = COORD_BITS'(10);

  localparam logic [BOX_BITS-1:0] BOX_LO_RST = '0;
  localparam logic [BOX_BITS-1:0] BOX_HI_RST = '1;

  localparam logic signed [SUM_BITS-1:0] DEPTH_MAX = SUM_BITS'((1 << (DEPTH_BITS - 1)) - 1);
  localparam logic signed [SUM_BITS-1:0] DEPTH_MIN = -DEPTH_MAX - SUM_BITS'(1);

  localparam logic signed [PIXEL_BITS-1:0] PIX_MAX = {1'b0, {(PIXEL_BITS-1){1'b1}}};
  localparam logic signed [PIXEL_BITS-1:0] PIX_MIN = {1'b1, {(PIXEL_BITS-1){1'b0}}};

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_OFFSET_X   = 3'd0,
    REG_OFFSET_Y   = 3'd1,
    REG_OFFSET_Z   = 3'd2,
    REG_BOX_LEFT   = 3'd3,
    REG_BOX_RIGHT  = 3'd4,
    REG_BOX_TOP    = 3'd5,
    REG_BOX_BOTTOM = 3'd6,
    REG_BOX_MARGIN = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [OFS_BITS-1:0] offset_x;
    logic signed [OFS_BITS-1:0] offset_y;
    logic signed [OFS_BITS-1:0] offset_z;
  } offs_t;

  // per-point flags that ride along the divider chain
  typedef struct packed {
    logic                         dpos;
    logic                         pre;
    logic                         last;
    logic                         frac_u;
    logic                         frac_v;
    logic                         hi_u;
    logic                         lo_u;
    logic                         hi_v;
    logic                         lo_v;
    logic signed [DEPTH_BITS-1:0] depth;
  } side_t;

  typedef struct packed {
    logic [DIV_BITS-1:0]   rem_u;
    logic [DIV_BITS-1:0]   rem_v;
    logic [PIXEL_BITS-1:0] num_u;
    logic [PIXEL_BITS-1:0] num_v;
    logic [DIV_BITS-1:0]   divisor;
    side_t                 side;
  } div_t;

  function automatic logic signed [DEPTH_BITS-1:0] sat_depth(
    input logic signed [SUM_BITS-1:0] v
  );
    logic signed [SUM_BITS-1:0] r;
    r = v;
    if (v > DEPTH_MAX) r = DEPTH_MAX;
    if (v < DEPTH_MIN) r = DEPTH_MIN;
    return DEPTH_BITS'(r);
  endfunction

endpackage
`default_nettype wire

/* sv/lpib_ifs.sv */
// Valid/ready channel interfaces for points in and gate results out.
// Uses lpib_pkg for field widths.
`default_nettype none
interface lpib_point_if import lpib_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_fwd;
  logic signed [COORD_BITS-1:0] point_side;
  logic signed [COORD_BITS-1:0] point_up;
  logic                         pass_end;
  modport source (output valid, point_fwd, point_side, point_up, pass_end, input ready);
  modport sink (input valid, point_fwd, point_side, point_up, pass_end, output ready);
endinterface

interface lpib_result_if import lpib_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic                         kept;
  logic signed [PIXEL_BITS-1:0] pixel_col;
  logic signed [PIXEL_BITS-1:0] pixel_row;
  logic signed [DEPTH_BITS-1:0] depth;
  logic                         pass_done;
  logic                         any_kept;
  modport source (output valid, kept, pixel_col, pixel_row, depth, pass_done, any_kept,
                  input ready);
  modport sink (input valid, kept, pixel_col, pixel_row, depth, pass_done, any_kept,
                output ready);
endinterface
`default_nettype wire

/* sv/lpib_front.sv */
// Front pipeline: offsets, products, sector/noise tests, range check and
// divider setup. Four register stages. Uses lpib_pkg.
`default_nettype none
module lpib_front import lpib_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  offs_t                        offs,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] fwd,
  input  logic signed [COORD_BITS-1:0] side,
  input  logic signed [COORD_BITS-1:0] up,
  input  logic                         last,
  output logic                         dn_valid,
  output div_t                         dn,
  input  logic                         dn_ready
);

  logic a_valid, b_valid, c_valid;
  logic a_ready, b_ready, c_ready, d_ready;

  // stage A
  logic signed [COORD_BITS-1:0] a_x;
  logic [COORD_BITS-1:0]        a_ay;
  logic                         a_ynz, a_xpos, a_noise, a_last;
  logic signed [SUM_BITS-1:0]   a_d, a_yo, a_zo;
  // stage B
  logic signed [PROD_BITS-1:0]  b_pu, b_pcu, b_pv, b_pcv;
  logic signed [SEC_BITS-1:0]   b_sx;
  logic [SEC_BITS-2:0]          b_sy;
  logic                         b_ynz, b_xpos, b_noise, b_last;
  logic signed [SUM_BITS-1:0]   b_d;
  // stage C
  logic signed [NSH_BITS-1:0]   c_nsu, c_nsv;
  logic                         c_fu, c_fv, c_pre, c_last;
  logic signed [SUM_BITS-1:0]   c_d;

  logic [COORD_BITS-1:0]        ay;
  logic signed [SUMP_BITS-1:0]  sum_u, sum_v;
  logic signed [CMP_BITS-1:0]   dsh, ns_u, ns_v, nn_u, nn_v;

  assign d_ready  = !dn_valid || dn_ready;
  assign c_ready  = !c_valid || d_ready;
  assign b_ready  = !b_valid || c_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  assign ay    = side[COORD_BITS-1] ? COORD_BITS'(-side) : COORD_BITS'(side);
  assign sum_u = SUMP_BITS'(b_pu) + SUMP_BITS'(b_pcu);
  assign sum_v = SUMP_BITS'(b_pv) + SUMP_BITS'(b_pcv);
  assign dsh   = CMP_BITS'($signed({c_d, {(PIXEL_BITS-1){1'b0}}}));
  assign ns_u  = CMP_BITS'(c_nsu);
  assign ns_v  = CMP_BITS'(c_nsv);
  // bias by 2^(PIXEL_BITS-1)*d so the quotient is unsigned
  assign nn_u  = ns_u + dsh;
  assign nn_v  = ns_v + dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      b_valid  <= 1'b0;
      c_valid  <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (a_ready) a_valid <= in_valid;
      if (b_ready) b_valid <= a_valid;
      if (c_ready) c_valid <= b_valid;
      if (d_ready) dn_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_x     <= fwd;
      a_ay    <= ay;
      a_ynz   <= (side != '0);
      a_xpos  <= (fwd > $signed(COORD_BITS'(0)));
      a_noise <= (fwd > NOISE_S) && (ay > NOISE_U);
      a_last  <= last;
      a_d     <= SUM_BITS'(fwd) + SUM_BITS'(offs.offset_z);
      a_yo    <= SUM_BITS'(side) + SUM_BITS'(offs.offset_x);
      a_zo    <= SUM_BITS'(up) + SUM_BITS'(offs.offset_y);
    end
    if (b_ready) begin
      b_pu    <= a_yo * FX_Q10;
      b_pcu   <= a_d * CX_Q10;
      b_pv    <= a_zo * FY_Q10;
      b_pcv   <= a_d * CY_Q10;
      b_sx    <= a_x * SLOPE_DEN;
      b_sy    <= a_ay * SLOPE_NUM;
      b_ynz   <= a_ynz;
      b_xpos  <= a_xpos;
      b_noise <= a_noise;
      b_last  <= a_last;
      b_d     <= a_d;
    end
    if (c_ready) begin
      c_nsu  <= sum_u[SUMP_BITS-1:Q_FRAC];
      c_nsv  <= sum_v[SUMP_BITS-1:Q_FRAC];
      c_fu   <= |sum_u[Q_FRAC-1:0];
      c_fv   <= |sum_v[Q_FRAC-1:0];
      c_pre  <= b_xpos && b_ynz && b_noise && (b_sx > $signed({1'b0, b_sy}));
      c_last <= b_last;
      c_d    <= b_d;
    end
    if (d_ready) begin
      dn.rem_u       <= nn_u[PIXEL_BITS +: DIV_BITS];
      dn.rem_v       <= nn_v[PIXEL_BITS +: DIV_BITS];
      dn.num_u       <= nn_u[PIXEL_BITS-1:0];
      dn.num_v       <= nn_v[PIXEL_BITS-1:0];
      dn.divisor     <= c_d[DIV_BITS-1:0];
      dn.side.dpos   <= (c_d > $signed(SUM_BITS'(0)));
      dn.side.pre    <= c_pre;
      dn.side.last   <= c_last;
      dn.side.frac_u <= c_fu;
      dn.side.frac_v <= c_fv;
      dn.side.hi_u   <= (ns_u >= dsh);
      dn.side.lo_u   <= (ns_u < -dsh);
      dn.side.hi_v   <= (ns_v >= dsh);
      dn.side.lo_v   <= (ns_v < -dsh);
      dn.side.depth  <= sat_depth(c_d);
    end
  end

endmodule
`default_nettype wire

/* sv/lpib_div_cell.sv */
// One cell of the restoring divider chain: one quotient bit of the column
// and of the row per cell. Uses lpib_pkg.
`default_nettype none
module lpib_div_cell import lpib_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic up_valid,
  input  div_t up,
  output logic up_ready,
  output logic dn_valid,
  output div_t dn,
  input  logic dn_ready
);

  logic [DIV_BITS:0] t_u, t_v, dv;
  logic              ge_u, ge_v;
  div_t              nxt;

  assign up_ready = !dn_valid || dn_ready;
  assign dv   = {1'b0, up.divisor};
  assign t_u  = {up.rem_u, up.num_u[PIXEL_BITS-1]};
  assign t_v  = {up.rem_v, up.num_v[PIXEL_BITS-1]};
  assign ge_u = (t_u >= dv);
  assign ge_v = (t_v >= dv);

  always_comb begin
    nxt       = up;
    nxt.rem_u = ge_u ? DIV_BITS'(t_u - dv) : t_u[DIV_BITS-1:0];
    nxt.rem_v = ge_v ? DIV_BITS'(t_v - dv) : t_v[DIV_BITS-1:0];
    // shift the next dividend bit out, the quotient bit in
    nxt.num_u = {up.num_u[PIXEL_BITS-2:0], ge_u};
    nxt.num_v = {up.num_v[PIXEL_BITS-2:0], ge_v};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      dn <= nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/lidar_point_image_box_gate_unit.sv */
// One point enters per clock and one result leaves per clock when the output
// side keeps up; from acceptance to result each point passes four front
// stages (offsets, Q10 projection products, sector test, range check), a
// chain of PIXEL_BITS divider cells that each resolve one bit of column and
// row, and the output register. Column and row are floor(u) and floor(v)
// saturated to PIXEL_BITS; depth is fwd plus offset_z. A point with depth at
// or below zero reports zero pixels and is never kept. any_kept is sticky
// across one pass and clears after the result that carries pass_done. Write
// configuration only while no point is in flight.
// Depends on lpib_pkg, lpib_ifs, lpib_front and lpib_div_cell.
`default_nettype none
module lidar_point_image_box_gate_unit import lpib_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  lpib_point_if.sink                point,
  lpib_result_if.source             result
);

  offs_t                  offs;
  logic [BOX_BITS-1:0]    box_left, box_right, box_top, box_bottom;
  logic [MARGIN_BITS-1:0] box_margin;
  logic                   kept_seen;

  logic                   cv [PIXEL_BITS+1];
  logic                   cr [PIXEL_BITS+1];
  div_t                   cd [PIXEL_BITS+1];

  logic                         o_valid, o_kept, o_last, o_any;
  logic signed [PIXEL_BITS-1:0] o_col, o_row;
  logic signed [DEPTH_BITS-1:0] o_depth;
  logic                         out_ready;

  div_t                         fin;
  logic signed [PIXEL_BITS-1:0] q_u, q_v, col, row;
  logic signed [QC_BITS-1:0]    qe_u, qe_v, lo_h, hi_h, lo_v, hi_v;
  logic                         in_u, in_v, kept, any;

  always_ff @(posedge clk) begin
    if (rst) begin
      offs.offset_x <= '0;
      offs.offset_y <= '0;
      offs.offset_z <= '0;
      box_left      <= BOX_LO_RST;
      box_right     <= BOX_HI_RST;
      box_top       <= BOX_LO_RST;
      box_bottom    <= BOX_HI_RST;
      box_margin    <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_OFFSET_X:   offs.offset_x <= cfg_data[OFS_BITS-1:0];
        REG_OFFSET_Y:   offs.offset_y <= cfg_data[OFS_BITS-1:0];
        REG_OFFSET_Z:   offs.offset_z <= cfg_data[OFS_BITS-1:0];
        REG_BOX_LEFT:   box_left      <= cfg_data[BOX_BITS-1:0];
        REG_BOX_RIGHT:  box_right     <= cfg_data[BOX_BITS-1:0];
        REG_BOX_TOP:    box_top       <= cfg_data[BOX_BITS-1:0];
        REG_BOX_BOTTOM: box_bottom    <= cfg_data[BOX_BITS-1:0];
        REG_BOX_MARGIN: box_margin    <= cfg_data[MARGIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  lpib_front u_front (
    .clk      (clk),
    .rst      (rst),
    .offs     (offs),
    .in_valid (point.valid),
    .in_ready (point.ready),
    .fwd      (point.point_fwd),
    .side     (point.point_side),
    .up       (point.point_up),
    .last     (point.pass_end),
    .dn_valid (cv[0]),
    .dn       (cd[0]),
    .dn_ready (cr[0])
  );

  for (genvar i = 0; i < PIXEL_BITS; i++) begin : g_cell
    lpib_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (cv[i]),
      .up       (cd[i]),
      .up_ready (cr[i]),
      .dn_valid (cv[i+1]),
      .dn       (cd[i+1]),
      .dn_ready (cr[i+1])
    );
  end

  assign out_ready     = !o_valid || result.ready;
  assign cr[PIXEL_BITS] = out_ready;
  assign fin           = cd[PIXEL_BITS];

  // remove the bias: flipping the top bit subtracts 2^(PIXEL_BITS-1)
  assign q_u  = $signed({~fin.num_u[PIXEL_BITS-1], fin.num_u[PIXEL_BITS-2:0]});
  assign q_v  = $signed({~fin.num_v[PIXEL_BITS-1], fin.num_v[PIXEL_BITS-2:0]});
  assign qe_u = QC_BITS'(q_u);
  assign qe_v = QC_BITS'(q_v);
  assign lo_h = QC_BITS'($signed({1'b0, box_left})) - QC_BITS'($signed({1'b0, box_margin}));
  assign hi_h = QC_BITS'($signed({1'b0, box_right})) + QC_BITS'($signed({1'b0, box_margin}));
  assign lo_v = QC_BITS'($signed({1'b0, box_top})) - QC_BITS'($signed({1'b0, box_margin}));
  assign hi_v = QC_BITS'($signed({1'b0, box_bottom})) + QC_BITS'($signed({1'b0, box_margin}));

  always_comb begin
    col = q_u;
    if (fin.side.hi_u) col = PIX_MAX;
    if (fin.side.lo_u) col = PIX_MIN;
    if (!fin.side.dpos) col = '0;
    row = q_v;
    if (fin.side.hi_v) row = PIX_MAX;
    if (fin.side.lo_v) row = PIX_MIN;
    if (!fin.side.dpos) row = '0;
    // strict lower edge: an exact hit on the edge fails
    in_u = !fin.side.hi_u && !fin.side.lo_u && (qe_u < hi_h) &&
           ((qe_u > lo_h) ||
            ((qe_u == lo_h) && (fin.side.frac_u || (fin.rem_u != '0))));
    in_v = !fin.side.hi_v && !fin.side.lo_v && (qe_v < hi_v) &&
           ((qe_v > lo_v) ||
            ((qe_v == lo_v) && (fin.side.frac_v || (fin.rem_v != '0))));
    kept = fin.side.dpos && fin.side.pre && in_u && in_v;
    any  = kept_seen || kept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid   <= 1'b0;
      kept_seen <= 1'b0;
    end else if (out_ready) begin
      o_valid <= cv[PIXEL_BITS];
      if (cv[PIXEL_BITS]) begin
        kept_seen <= fin.side.last ? 1'b0 : any;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      o_kept  <= kept;
      o_col   <= col;
      o_row   <= row;
      o_depth <= fin.side.depth;
      o_last  <= fin.side.last;
      o_any   <= any;
    end
  end

  assign result.valid     = o_valid;
  assign result.kept      = o_kept;
  assign result.pixel_col = o_col;
  assign result.pixel_row = o_row;
  assign result.depth     = o_depth;
  assign result.pass_done = o_last;
  assign result.any_kept  = o_any;

endmodule
`default_nettype wire

/* sv/lpib_checker.sv */
// Port-level checks on the gate unit, bound to the top level.
// Depends on assert_macros.svh and lpib_pkg.
`default_nettype none
`include "assert_macros.svh"
module lpib_checker import lpib_pkg::*; (
  input logic                         clk,
  input logic                         rst,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic                         res_kept,
  input logic                         res_any,
  input logic signed [PIXEL_BITS-1:0] res_col,
  input logic signed [PIXEL_BITS-1:0] res_row,
  input logic signed [DEPTH_BITS-1:0] res_depth
);

  `LPIB_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !res_valid)
  `LPIB_ASSERT(a_stall_hold, clk, rst, res_valid && !res_ready |=> res_valid && $stable(res_col) && $stable(res_row) && $stable(res_depth))
  `LPIB_ASSERT(a_kept_sticky, clk, rst, res_valid && res_kept |-> res_any)
  `LPIB_ASSERT(a_depth_gate, clk, rst, res_valid && (res_depth <= 0) |-> !res_kept && (res_col == 0) && (res_row == 0))

endmodule

bind lidar_point_image_box_gate_unit lpib_checker u_lpib_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_kept  (result.kept),
  .res_any   (result.any_kept),
  .res_col   (result.pixel_col),
  .res_row   (result.pixel_row),
  .res_depth (result.depth)
);
`default_nettype wire
